// ===== sv/chd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and constants of the canonical huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int WINDOW_W  = 16;
  localparam int CODE_W    = 17;
  localparam int LIMIT_W   = 17;
  localparam int SYM_IDX_W = 12;
  localparam int OFFSET_W  = 18;
  localparam int LEN_IDX_W = 4;
  localparam int LEN_W     = 5;

  typedef enum logic [1:0] {
    OP_LOAD_COUNT  = 2'd0,
    OP_LOAD_SYMBOL = 2'd1,
    OP_BUILD       = 2'd2,
    OP_DECODE      = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_CMP,
    S_SEL,
    S_RD
  } state_t;

  // broadcast controls from the sequencer to every length cell
  typedef struct packed {
    logic                 count_we;
    logic [LEN_IDX_W-1:0] count_idx;
    logic [7:0]           count_val;
    logic                 cmp;
  } cell_ctrl_t;

  // first-match selection passed down the cell row
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] pos;
    logic [LEN_W-1:0]    len;
  } sel_t;

endpackage
`default_nettype wire

// ===== sv/chd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_in_if
// Request channel: opcode, slot, value and bit window.
// ----------------------------------------------------------------------------
interface chd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  slot;
  logic [7:0]  value;
  logic [15:0] window;

  modport source (output valid, opcode, slot, value, window, input ready);
  modport sink   (input valid, opcode, slot, value, window, output ready);
endinterface
`default_nettype wire

// ===== sv/chd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_out_if
// Result channel: symbol, code length and status.
// ----------------------------------------------------------------------------
interface chd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [4:0] code_length;
  logic [1:0] status;

  modport source (output valid, symbol, code_length, status, input ready);
  modport sink   (input valid, symbol, code_length, status, output ready);
endinterface
`default_nettype wire

// ===== sv/chd_len_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chd_len_cell
// One code length: holds its count, limit and offset, passes the build
// wave and the first-match selection to the next length.
// ----------------------------------------------------------------------------
module chd_len_cell
  import chd_pkg::*;
#(
  parameter int LEN = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [WINDOW_W-1:0]  window,
  input  wire logic                 build_in,
  input  wire logic [CODE_W-1:0]    code_in,
  input  wire logic [SYM_IDX_W-1:0] sym_in,
  output logic                      build_out,
  output logic [CODE_W-1:0]         code_out,
  output logic [SYM_IDX_W-1:0]      sym_out,
  input  wire sel_t                 sel_in,
  output sel_t                      sel_out
);

  localparam logic [CODE_W-1:0] CAP = CODE_W'(32'd1 << LEN);

  logic [7:0]          count;
  logic [LIMIT_W-1:0]  limit;
  logic [OFFSET_W-1:0] offset;
  logic                hit;
  logic [OFFSET_W-1:0] pos;

  logic [CODE_W:0]     sum;
  logic [CODE_W-1:0]   capped;
  logic [LIMIT_W-1:0]  lim;
  logic [OFFSET_W-1:0] offset_new;
  logic [OFFSET_W-1:0] pos_new;

  always_comb begin
    sum        = {1'b0, code_in} + {(CODE_W - 7)'(0), count};
    capped     = (sum > {1'b0, CAP}) ? CAP : sum[CODE_W-1:0];
    // capped never exceeds 2^LEN, so the aligned limit stays within 0x10000
    lim        = capped << (WINDOW_W - LEN);
    offset_new = OFFSET_W'($signed({1'b0, sym_in}) - $signed({1'b0, code_in}));
    pos_new    = OFFSET_W'({2'b00, window >> (WINDOW_W - LEN)}) + offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      build_out <= 1'b0;
    end else begin
      build_out <= build_in;
      if (ctrl.count_we && ctrl.count_idx == LEN_IDX_W'(LEN - 1)) begin
        count <= ctrl.count_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build_in) begin
      limit    <= lim;
      offset   <= offset_new;
      code_out <= {capped[CODE_W-2:0], 1'b0};
      sym_out  <= sym_in + {(SYM_IDX_W - 8)'(0), count};
    end
    if (ctrl.cmp) begin
      hit <= {1'b0, window} < limit;
      pos <= pos_new;
    end
  end

  // shorter lengths win
  always_comb begin
    sel_out.found = sel_in.found | hit;
    sel_out.pos   = sel_in.found ? sel_in.pos : pos;
    sel_out.len   = sel_in.found ? sel_in.len : LEN_W'(LEN);
  end

endmodule
`default_nettype wire

// ===== sv/jpeg_canonical_huffman_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_canonical_huffman_decoder
// Canonical huffman decoder with a row of per-length cells and a symbol
// memory.
// ----------------------------------------------------------------------------
//  channel | dir | fields                               | handshake
//  req     | in  | opcode, slot, value, window          | valid / ready
//  rsp     | out | symbol, code_length, status          | valid / ready
//
//  a build runs while the wave moves one cell per cycle down the length row;
//  decode steps: cell compare register, first-match select with the
//  symbol memory read, result register; decode before a build goes
//  straight to the result register with status not built
//  reset clears counts and the built flag; the symbol memory is not cleared
//  a result waiting in the output word holds the sequencer; loads still pass
// ----------------------------------------------------------------------------
module jpeg_canonical_huffman_decoder
  import chd_pkg::*;
#(
  parameter int MAX_CODE_LEN = 16,
  parameter int MAX_SYMBOLS  = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  chd_in_if.sink    req,
  chd_out_if.source rsp
);

  localparam int ADDR_W = $clog2(MAX_SYMBOLS);
  localparam logic [OFFSET_W-1:0] SYM_LIMIT = OFFSET_W'(MAX_SYMBOLS);

  state_t state, state_next;
  logic   tables_built;
  logic   accept;
  logic   build_start;
  logic   sym_we;
  logic   rsp_load;
  logic   pos_bad;
  cell_ctrl_t ctrl;

  logic [WINDOW_W-1:0] win;
  logic [1:0]          res_status;
  logic [LEN_W-1:0]    res_len;
  logic [7:0]          rd_data;
  logic [7:0]          mem [MAX_SYMBOLS];

  logic                 build_chain [MAX_CODE_LEN+1];
  logic [CODE_W-1:0]    code_chain  [MAX_CODE_LEN+1];
  logic [SYM_IDX_W-1:0] sym_chain   [MAX_CODE_LEN+1];
  sel_t                 sel_chain   [MAX_CODE_LEN+1];

  assign build_chain[0] = build_start;
  assign code_chain[0]  = '0;
  assign sym_chain[0]   = '0;
  assign sel_chain[0]   = '0;

  for (genvar g = 0; g < MAX_CODE_LEN; g++) begin : g_cell
    chd_len_cell #(.LEN(g + 1)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .window    (win),
      .build_in  (build_chain[g]),
      .code_in   (code_chain[g]),
      .sym_in    (sym_chain[g]),
      .build_out (build_chain[g+1]),
      .code_out  (code_chain[g+1]),
      .sym_out   (sym_chain[g+1]),
      .sel_in    (sel_chain[g]),
      .sel_out   (sel_chain[g+1])
    );
  end

  assign accept = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(req.opcode)) inside
            OP_BUILD:       state_next = S_BUILD;
            OP_DECODE:      state_next = tables_built ? S_CMP : S_RD;
            OP_LOAD_COUNT,
            OP_LOAD_SYMBOL: state_next = S_IDLE;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_BUILD: if (build_chain[MAX_CODE_LEN]) state_next = S_IDLE;
      S_CMP:   state_next = S_SEL;
      S_SEL:   state_next = S_RD;
      S_RD:    if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready      = (state == S_IDLE);
    build_start    = accept && op_t'(req.opcode) == OP_BUILD;
    ctrl.count_we  = accept && op_t'(req.opcode) == OP_LOAD_COUNT
                     && req.slot < 8'(MAX_CODE_LEN);
    ctrl.count_idx = req.slot[LEN_IDX_W-1:0];
    ctrl.count_val = req.value;
    ctrl.cmp       = (state == S_CMP);
    sym_we         = accept && op_t'(req.opcode) == OP_LOAD_SYMBOL
                     && {1'b0, req.slot} < 9'(MAX_SYMBOLS);
    rsp_load       = (state == S_RD) && (!rsp.valid || rsp.ready);
  end

  assign pos_bad = sel_chain[MAX_CODE_LEN].pos[OFFSET_W-1]
                   || $signed(sel_chain[MAX_CODE_LEN].pos) >= $signed(SYM_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tables_built <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.count_we || sym_we) begin
        tables_built <= 1'b0;
      end else if (state == S_BUILD && build_chain[MAX_CODE_LEN]) begin
        tables_built <= 1'b1;
      end
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      mem[req.slot[ADDR_W-1:0]] <= req.value;
    end
    if (accept) begin
      win <= req.window;
    end
    if (accept && op_t'(req.opcode) == OP_DECODE && !tables_built) begin
      res_status <= ST_NOT_BUILT;
    end
    if (state == S_SEL) begin
      rd_data    <= mem[sel_chain[MAX_CODE_LEN].pos[ADDR_W-1:0]];
      res_len    <= sel_chain[MAX_CODE_LEN].len;
      res_status <= (!sel_chain[MAX_CODE_LEN].found || pos_bad) ? ST_INVALID : ST_OK;
    end
    if (rsp_load) begin
      rsp.status      <= res_status;
      rsp.symbol      <= (res_status == ST_OK) ? rd_data : 8'd0;
      rsp.code_length <= (res_status == ST_OK) ? res_len : '0;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.symbol == 8'd0 && rsp.code_length == '0)
    else $error("error result carries symbol or length");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OK |->
      rsp.code_length != '0 && rsp.code_length <= LEN_W'(MAX_CODE_LEN))
    else $error("ok result with bad code length");

  a_built_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(tables_built) |-> $past(state) == S_BUILD)
    else $error("tables marked built outside a build");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    ctrl.count_we || sym_we |=> !tables_built)
    else $error("load did not clear built flag");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("waiting result changed");
`endif

endmodule
`default_nettype wire
